/* hdl/l4hx_pkg.sv */
// Shared types and constants for the IPv4 L4 header extractor.
package l4hx_pkg;

	localparam logic [7:0] IP_MIN_HDR     = 8'd20;
	localparam logic [7:0] TCP_MIN_HDR    = 8'd20;
	localparam logic [7:0] UDP_HDR        = 8'd8;
	localparam logic [7:0] PROTO_TCP      = 8'd6;
	localparam logic [7:0] PROTO_UDP      = 8'd17;
	localparam logic [3:0] IP_VERSION     = 4'd4;
	localparam logic [7:0] BYTE_INDEX_MAX = 8'd255;

	// IPv4 header byte positions
	localparam logic [7:0] POS_VER_IHL  = 8'd0;
	localparam logic [7:0] POS_TLEN_HI  = 8'd2;
	localparam logic [7:0] POS_TLEN_LO  = 8'd3;
	localparam logic [7:0] POS_FRAG_HI  = 8'd6;
	localparam logic [7:0] POS_FRAG_LO  = 8'd7;
	localparam logic [7:0] POS_PROTO    = 8'd9;
	localparam logic [7:0] POS_SRC_LO   = 8'd12;
	localparam logic [7:0] POS_SRC_HI   = 8'd15;
	localparam logic [7:0] POS_DST_LO   = 8'd16;
	localparam logic [7:0] POS_DST_HI   = 8'd19;

	// transport header byte offsets
	localparam logic [7:0] OFF_SPORT_HI = 8'd0;
	localparam logic [7:0] OFF_SPORT_LO = 8'd1;
	localparam logic [7:0] OFF_DPORT_HI = 8'd2;
	localparam logic [7:0] OFF_DPORT_LO = 8'd3;
	localparam logic [7:0] OFF_ULEN_HI  = 8'd4;
	localparam logic [7:0] OFF_ULEN_LO  = 8'd5;
	localparam logic [7:0] OFF_TCP_DOFF = 8'd12;
	localparam logic [7:0] OFF_TCP_FLAG = 8'd13;

	typedef struct packed {
		logic [7:0]  version_ihl;
		logic [15:0] total_length;
		logic [15:0] fragment;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] l4_sport;
		logic [15:0] l4_dport;
		logic [15:0] udp_length;
		logic [3:0]  tcp_offset;
		logic [7:0]  l4_flags;
	} hdr_fields_t;

	typedef struct packed {
		logic       pending;
		logic [7:0] len;
	} eval_req_t;

endpackage

/* hdl/ipv4_l4_header_extractor_core.sv */
// Top level of the IPv4 L4 header extractor.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------------
//   in      | sink      | in_valid / in_stall | packet_byte, last_byte
//   out     | source    | out_valid/out_stall | packet_ok .. payload_length (one/packet)
//
// One byte transfer per cycle while in_stall is low. The byte is captured
// straight into the header field registers at the edge that accepts it; the
// last byte arms the evaluation request, and the checked result moves from it
// into the output register, raising out_valid, when that is empty or unstalled.
// Reset clears the byte counter, all header field registers and the output valid.
// in_stall rises only when an armed evaluation cannot enter a stalled, full
// output register; otherwise bytes keep flowing while a result waits.
module ipv4_l4_header_extractor_core import l4hx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        packet_ok,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [7:0]  proto_number,
	output logic [15:0] ip_total_length,
	output logic        ports_valid,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [7:0]  tcp_flag_bits,
	output logic [15:0] payload_length
);

	hdr_fields_t hdr;
	eval_req_t   req;
	logic        take;
	logic        load_ok;
	logic        accept;

	// hold input while a finished header still needs the stalled result slot:
	// the next byte would overwrite the fields it reads
	assign in_stall = req.pending && !load_ok;
	assign accept   = in_valid && !in_stall;

	l4hx_capture u_capture (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.drain       (take),
		.hdr         (hdr),
		.req         (req)
	);

	// evaluate from pre-edge field values, so the next packet's first byte
	// may be captured in the same cycle the result is loaded
	l4hx_eval u_eval (
		.clk             (clk),
		.arst_n          (arst_n),
		.hdr             (hdr),
		.req             (req),
		.out_stall       (out_stall),
		.take            (take),
		.load_ok         (load_ok),
		.out_valid       (out_valid),
		.packet_ok       (packet_ok),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.proto_number    (proto_number),
		.ip_total_length (ip_total_length),
		.ports_valid     (ports_valid),
		.source_port     (source_port),
		.dest_port       (dest_port),
		.tcp_flag_bits   (tcp_flag_bits),
		.payload_length  (payload_length)
	);

endmodule

/* hdl/l4hx_capture.sv */
// Byte position tracking and header field capture.
module l4hx_capture import l4hx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic        drain,
	output hdr_fields_t hdr,
	output eval_req_t   req
);

	logic [7:0]  byte_index_q;
	hdr_fields_t hdr_q;
	eval_req_t   req_q;
	logic [5:0]  hl_cap;
	logic [7:0]  off;
	logic        in_xport;
	logic [7:0]  len_next;

	always_comb begin
		// the IHL written by this very byte already positions the transport header
		hl_cap   = {(byte_index_q == POS_VER_IHL) ? packet_byte[3:0]
				: hdr_q.version_ihl[3:0], 2'b00};
		in_xport = byte_index_q >= {2'b00, hl_cap};
		off      = byte_index_q - {2'b00, hl_cap};
		len_next = (byte_index_q == BYTE_INDEX_MAX) ? BYTE_INDEX_MAX
				: byte_index_q + 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			hdr_q        <= '0;
			req_q        <= '0;
		end else begin
			if (accept) begin
				byte_index_q <= last_byte ? 8'd0 : len_next;
				if (byte_index_q == POS_VER_IHL)
					hdr_q.version_ihl <= packet_byte;
				else if (byte_index_q == POS_TLEN_HI)
					hdr_q.total_length[15:8] <= packet_byte;
				else if (byte_index_q == POS_TLEN_LO)
					hdr_q.total_length[7:0] <= packet_byte;
				else if (byte_index_q == POS_FRAG_HI)
					hdr_q.fragment[15:8] <= packet_byte;
				else if (byte_index_q == POS_FRAG_LO)
					hdr_q.fragment[7:0] <= packet_byte;
				else if (byte_index_q == POS_PROTO)
					hdr_q.protocol <= packet_byte;
				else if (byte_index_q >= POS_SRC_LO && byte_index_q <= POS_SRC_HI)
					hdr_q.src_addr <= {hdr_q.src_addr[23:0], packet_byte};
				else if (byte_index_q >= POS_DST_LO && byte_index_q <= POS_DST_HI)
					hdr_q.dst_addr <= {hdr_q.dst_addr[23:0], packet_byte};

				if (in_xport) begin
					case (off)
						OFF_SPORT_HI: hdr_q.l4_sport[15:8]   <= packet_byte;
						OFF_SPORT_LO: hdr_q.l4_sport[7:0]    <= packet_byte;
						OFF_DPORT_HI: hdr_q.l4_dport[15:8]   <= packet_byte;
						OFF_DPORT_LO: hdr_q.l4_dport[7:0]    <= packet_byte;
						OFF_ULEN_HI:  hdr_q.udp_length[15:8] <= packet_byte;
						OFF_ULEN_LO:  hdr_q.udp_length[7:0]  <= packet_byte;
						OFF_TCP_DOFF: hdr_q.tcp_offset       <= packet_byte[7:4];
						OFF_TCP_FLAG: hdr_q.l4_flags         <= packet_byte;
						default: ;
					endcase
				end
			end

			// a new last byte arms evaluation; otherwise clear once handed off
			if (accept && last_byte) begin
				req_q.pending <= 1'b1;
				req_q.len     <= len_next;
			end else if (drain) begin
				req_q.pending <= 1'b0;
			end
		end
	end

	assign hdr = hdr_q;
	assign req = req_q;

endmodule

/* hdl/l4hx_eval.sv */
// Header checks and the registered result stage.
module l4hx_eval import l4hx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hdr_fields_t hdr,
	input  eval_req_t   req,
	input  logic        out_stall,
	output logic        take,
	output logic        load_ok,
	output logic        out_valid,
	output logic        packet_ok,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [7:0]  proto_number,
	output logic [15:0] ip_total_length,
	output logic        ports_valid,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [7:0]  tcp_flag_bits,
	output logic [15:0] payload_length
);

	logic        out_valid_q;
	logic        ok_q, pv_q;
	logic [31:0] src_q, dst_q;
	logic [7:0]  proto_q, flags_q;
	logic [15:0] tlen_q, sport_q, dport_q, plen_q;

	logic [7:0]  hl;
	logic [7:0]  thl;
	logic [7:0]  tl;
	logic [16:0] tcp_end, udp_end;
	logic        ok, base_ok, tcp_ok, udp_ok, pv;
	logic [15:0] plen;

	always_comb begin
		hl      = {2'b00, hdr.version_ihl[3:0], 2'b00};
		thl     = {2'b00, hdr.tcp_offset, 2'b00};
		tl      = req.len - hl;
		tcp_end = {9'd0, hl} + {9'd0, thl};
		udp_end = {9'd0, hl} + {1'b0, hdr.udp_length};

		ok = (req.len >= IP_MIN_HDR) && (hdr.version_ihl[7:4] == IP_VERSION)
			&& (hl >= IP_MIN_HDR);
		base_ok = ok && (hdr.total_length >= {8'd0, hl})
			&& (hdr.fragment[12:0] == 13'd0) && (req.len >= hl);
		tcp_ok = base_ok && (hdr.protocol == PROTO_TCP) && (tl >= TCP_MIN_HDR)
			&& (thl >= TCP_MIN_HDR) && (thl <= tl)
			&& (tcp_end <= {1'b0, hdr.total_length});
		udp_ok = base_ok && (hdr.protocol == PROTO_UDP) && (tl >= UDP_HDR)
			&& (hdr.udp_length >= {8'd0, UDP_HDR})
			&& (udp_end <= {1'b0, hdr.total_length});
		pv = tcp_ok || udp_ok;

		if (tcp_ok)
			plen = hdr.total_length - tcp_end[15:0];
		else if (udp_ok)
			plen = hdr.udp_length - {8'd0, UDP_HDR};
		else
			plen = '0;
	end

	assign load_ok = !out_valid_q || !out_stall;
	assign take    = req.pending && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= req.pending;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ok_q    <= ok;
			src_q   <= ok ? hdr.src_addr : '0;
			dst_q   <= ok ? hdr.dst_addr : '0;
			proto_q <= ok ? hdr.protocol : '0;
			tlen_q  <= ok ? hdr.total_length : '0;
			pv_q    <= pv;
			sport_q <= pv ? hdr.l4_sport : '0;
			dport_q <= pv ? hdr.l4_dport : '0;
			flags_q <= tcp_ok ? hdr.l4_flags : '0;
			plen_q  <= plen;
		end
	end

	assign out_valid       = out_valid_q;
	assign packet_ok       = ok_q;
	assign source_address  = src_q;
	assign dest_address    = dst_q;
	assign proto_number    = proto_q;
	assign ip_total_length = tlen_q;
	assign ports_valid     = pv_q;
	assign source_port     = sport_q;
	assign dest_port       = dport_q;
	assign tcp_flag_bits   = flags_q;
	assign payload_length  = plen_q;

endmodule

/* hdl/l4hx_checker.sv */
// Port-level checks for the IPv4 L4 header extractor, bound to the top level.
module l4hx_checker import l4hx_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        packet_ok,
	input logic [31:0] source_address,
	input logic [31:0] dest_address,
	input logic [7:0]  proto_number,
	input logic [15:0] ip_total_length,
	input logic        ports_valid,
	input logic [15:0] source_port,
	input logic [15:0] dest_port,
	input logic [7:0]  tcp_flag_bits,
	input logic [15:0] payload_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !packet_ok |-> source_address == 32'd0 && dest_address == 32'd0
			&& proto_number == 8'd0 && ip_total_length == 16'd0 && !ports_valid)
		else $error("rejected packet carries nonzero fields");

	a_noports_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ports_valid |-> source_port == 16'd0 && dest_port == 16'd0
			&& tcp_flag_bits == 8'd0 && payload_length == 16'd0)
		else $error("transport fields nonzero without ports");

	a_ports_proto: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ports_valid |-> packet_ok
			&& (proto_number == PROTO_TCP || proto_number == PROTO_UDP))
		else $error("ports reported for non TCP/UDP or rejected packet");

	a_udp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ports_valid && proto_number == PROTO_UDP |-> tcp_flag_bits == 8'd0)
		else $error("UDP result carries TCP flags");

endmodule

bind ipv4_l4_header_extractor_core l4hx_checker u_l4hx_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.packet_ok       (packet_ok),
	.source_address  (source_address),
	.dest_address    (dest_address),
	.proto_number    (proto_number),
	.ip_total_length (ip_total_length),
	.ports_valid     (ports_valid),
	.source_port     (source_port),
	.dest_port       (dest_port),
	.tcp_flag_bits   (tcp_flag_bits),
	.payload_length  (payload_length)
);
